// File: rtl/core/mafs_pkg.sv
// Shared types, constants and lookup functions for the MPEG audio frame scanner.
// Used by mafs_ctrl, mafs_dp and mpeg_audio_frame_scanner_core. No dependencies.
`default_nettype none

package mafs_pkg;

  localparam int BYTE_W    = 8;
  localparam int BR_W      = 9;   // bitrate in kbps
  localparam int SR_W      = 16;  // sample rate in Hz
  localparam int LEN_W     = 12;  // frame length in bytes
  localparam int SUM_W     = 33;
  localparam int LOST_W    = 32;
  localparam int FC_OUT_W  = 24;
  localparam int K_W       = 18;
  localparam int NUM_W     = 27;  // bitrate * length coefficient
  localparam int DIV_STEPS = LEN_W;
  localparam int DCNT_W    = 4;
  localparam int PAYLOAD_W = 134;
  localparam int TDATA_W   = 136;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [LOST_W-1:0] LOST_MAX = '1;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  localparam logic [1:0] VER_MPEG1 = 2'd3;
  localparam logic [1:0] LAYER_I   = 2'd3;
  localparam logic [1:0] LAYER_II  = 2'd2;

  // frame length = K * br / sr, K already scaled by 1000
  localparam logic [K_W-1:0] K_LAYER1 = 18'd12000;
  localparam logic [K_W-1:0] K_LONG   = 18'd144000;
  localparam logic [K_W-1:0] K_SHORT  = 18'd72000;

  localparam logic [BR_W-1:0] RATE_V1 [3][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
  };

  localparam logic [BR_W-1:0] RATE_V2 [2][16] = '{
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  localparam logic [SR_W-1:0] SRATE [4][4] = '{
    '{16'd11025, 16'd12000, 16'd8000, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic div_step;  // one quotient bit
    logic load_hdr;  // frame result into output register
    logic set_skip;  // load skip count from frame length
    logic load_tot;  // totals result into output register
  } mafs_cmd_t;

  typedef struct packed {
    logic hdr_found; // window plus current byte form a valid header
  } mafs_stat_t;

  function automatic logic is_header(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3);
    logic ok;
    ok = 1'b1;
    if (b0 != 8'hFF) ok = 1'b0;
    if ((b1 & 8'hE0) != 8'hE0) ok = 1'b0;
    if ((b1 & 8'h18) == 8'h08) ok = 1'b0;   // reserved version
    if ((b1 & 8'h06) == 8'h00) ok = 1'b0;   // reserved layer
    if ((b2 & 8'hF0) == 8'hF0) ok = 1'b0;   // bad bitrate index
    if ((b2 & 8'hF0) == 8'h00) ok = 1'b0;   // free format
    if ((b2 & 8'h0C) == 8'h0C) ok = 1'b0;   // reserved sample rate
    if ((b3 & 8'h03) == 8'h02) ok = 1'b0;   // reserved emphasis
    return ok;
  endfunction

  function automatic logic [BR_W-1:0] rate_lookup(input logic [1:0] ver,
                                                  input logic [1:0] lay,
                                                  input logic [3:0] idx);
    logic [1:0] row;
    row = (lay == LAYER_I) ? 2'd0 : (lay == LAYER_II) ? 2'd1 : 2'd2;
    if (ver == VER_MPEG1) return RATE_V1[row][idx];
    else if (row == 2'd0) return RATE_V2[0][idx];
    else return RATE_V2[1][idx];
  endfunction

  function automatic logic [SR_W-1:0] srate_lookup(input logic [1:0] ver,
                                                   input logic [1:0] sidx);
    return SRATE[ver][sidx];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mpeg_audio_frame_scanner_core.sv
// Top level of the MPEG audio frame scanner: controller plus datapath.
// Depends on mafs_pkg, mafs_ctrl and mafs_dp.
//
// Usage:
//   Input stream: one audio byte per word on in_tdata, in_tlast marks the
//   final audio byte of a stream. The stream must start on the first frame.
//   Output stream: one word per frame header found (out_tuser = 0) and one
//   totals word after the final byte (out_tuser = 1). Totals carry frame
//   count, bitrate sum, lost window positions and the variable-rate flag.
//   cfg_wr_en/cfg_wr_data set the tag-frame flag; write it only while idle.
// Timing:
//   A byte that completes no header, other than the final byte, keeps the
//   scanner idle, so skipped frame bytes and sliding bytes stream at one per
//   cycle. The byte that completes a valid header starts a bit-serial length
//   divide, one quotient bit per cycle; the frame word is then loaded once
//   the output register is free. A totals word is loaded after the final
//   byte is accepted, or after the frame word that byte produced.
//   in_tready is low while a divide or a pending result is in progress.
// Stall: the output register holds its word while out_tready is low; new
//   bytes are still taken until one produces a further result.
// Reset: synchronous active low; clears all counters, the window and the
//   tag-frame flag. When the final byte is accepted the scan state returns
//   to reset values (the flag is kept), so the next byte begins a new stream.
`default_nettype none

module mpeg_audio_frame_scanner_core #(
  parameter int FRAME_COUNT_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic [7:0]                 in_tdata,
  input  wire logic                       in_tlast,   // last_byte
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // out_tdata: [1:0] version_id, [3:2] layer_id, [12:4] bitrate_kbps,
  //   [28:13] sample_rate_hz, [29] padding, [31:30] channel_mode,
  //   [43:32] frame_length, [67:44] frame_count, [100:68] total_bitrate_kbps,
  //   [132:101] lost_bytes, [133] variable_rate, [135:134] zero
  output logic [mafs_pkg::TDATA_W-1:0]    out_tdata,
  output logic                            out_tuser,  // [0] kind
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data // first_is_tag_frame
);
  import mafs_pkg::*;

  mafs_cmd_t  cmd;
  mafs_stat_t stat;

  mafs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  mafs_dp #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/core/mafs_ctrl.sv
// Sequencer for the MPEG audio frame scanner: input acceptance, divider
// stepping and output register loading. Depends on mafs_pkg.
`default_nettype none

module mafs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tlast,
  output logic                    in_tready,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  input  wire mafs_pkg::mafs_stat_t stat,
  output mafs_pkg::mafs_cmd_t     cmd
);
  import mafs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_HDR  = 4'b0100,
    S_TOT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_last_nxt = pend_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.hdr_found) begin
            state_nxt     = S_DIV;
            cnt_nxt       = '0;
            pend_last_nxt = in_tlast;
          end else if (in_tlast) begin
            state_nxt = S_TOT;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = S_HDR;
      end
      S_HDR: begin
        if (out_free) begin
          cmd.load_hdr = 1'b1;
          cmd.set_skip = !pend_last_r;
          state_nxt    = pend_last_r ? S_TOT : S_IDLE;
        end
      end
      S_TOT: begin
        if (out_free) begin
          cmd.load_tot = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_hdr || cmd.load_tot) out_valid_nxt = 1'b1;
    else if (out_tready)              out_valid_nxt = 1'b0;
    else                              out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_hdr_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.hdr_found) |=> (state_r == S_DIV && cnt_r == '0))
    else $error("header accept did not start divider");

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_hdr || cmd.load_tot) |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while held");

  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < DCNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_hdr && cmd.load_tot) && !(cmd.accept && cmd.div_step))
    else $error("conflicting commands");

endmodule

`default_nettype wire

// File: rtl/core/mafs_dp.sv
// Datapath of the MPEG audio frame scanner: header window, counters, bit-serial
// frame length divider and output register. Depends on mafs_pkg.
`default_nettype none

module mafs_dp #(
  parameter int FRAME_COUNT_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [mafs_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                         in_last,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,
  input  wire mafs_pkg::mafs_cmd_t          cmd,
  output mafs_pkg::mafs_stat_t              stat,
  output logic [mafs_pkg::TDATA_W-1:0]      out_tdata,
  output logic                              out_tuser
);
  import mafs_pkg::*;

  localparam logic [FRAME_COUNT_BITS-1:0] FC_MAX = '1;

  // scanning state
  logic                        tag_r;
  logic [23:0]                 win_r, win_nxt;
  logic [1:0]                  fill_r, fill_nxt;
  logic [LEN_W-1:0]            skip_r, skip_nxt;
  logic [FRAME_COUNT_BITS-1:0] frames_r, frames_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [LOST_W-1:0]           lost_r, lost_nxt;
  logic [BR_W-1:0]             prev_br_r, prev_br_nxt;
  logic                        rc_r, rc_nxt;
  logic [BR_W-1:0]             first_br_r, first_br_nxt;

  // values after the byte, before an end-of-stream clear
  logic [23:0]                 stp_win;
  logic [1:0]                  stp_fill;
  logic [LEN_W-1:0]            stp_skip;
  logic [FRAME_COUNT_BITS-1:0] stp_frames;
  logic [SUM_W-1:0]            stp_sum;
  logic [LOST_W-1:0]           stp_lost;
  logic [BR_W-1:0]             stp_prev;
  logic                        stp_rc;
  logic [BR_W-1:0]             stp_first;

  // pending frame and totals results
  logic [1:0]                  h_ver_r, h_lay_r, h_cm_r;
  logic [BR_W-1:0]             h_br_r;
  logic [SR_W-1:0]             h_sr_r;
  logic                        h_pad_r, h_rc_r;
  logic [FRAME_COUNT_BITS-1:0] h_fc_r;
  logic [SUM_W-1:0]            h_sum_r;
  logic [LOST_W-1:0]           h_lost_r;
  logic [FRAME_COUNT_BITS-1:0] t_fc_r, t_fc;
  logic [SUM_W-1:0]            t_sum_r, t_sum;
  logic [LOST_W-1:0]           t_lost_r;
  logic                        t_rc_r;

  // divider: remainder plus a shift register that turns into the quotient
  logic [SR_W-1:0]             rem_r;
  logic [LEN_W-1:0]            quo_r;
  logic [SR_W:0]               trial;
  logic                        trial_ge;

  logic [PAYLOAD_W-1:0]        out_data_r;
  logic                        out_kind_r;

  logic [7:0]       b0, b1, b2;
  logic [1:0]       ver, lay, sri, cm;
  logic [3:0]       bri;
  logic             pad, hdr_ok, at_window, miss;
  logic [BR_W-1:0]  br;
  logic [SR_W-1:0]  sr;
  logic [K_W-1:0]   kcoef;
  logic [NUM_W-1:0] num;
  logic [SUM_W:0]   sum_wide;
  logic [LOST_W+1:0] lost_wide;
  logic [LEN_W-1:0] len_pad;
  logic [LEN_W-1:0] len, skip_val;

  assign b0  = win_r[23:16];
  assign b1  = win_r[15:8];
  assign b2  = win_r[7:0];
  assign ver = b1[4:3];
  assign lay = b1[2:1];
  assign bri = b2[7:4];
  assign sri = b2[3:2];
  assign pad = b2[1];
  assign cm  = in_byte[7:6];

  assign hdr_ok         = is_header(b0, b1, b2, in_byte);
  assign at_window      = (skip_r == '0) && (fill_r == 2'd3);
  assign miss           = at_window && !hdr_ok;
  assign stat.hdr_found = at_window && hdr_ok;

  assign br    = rate_lookup(ver, lay, bri);
  assign sr    = srate_lookup(ver, sri);
  assign kcoef = (lay == LAYER_I) ? K_LAYER1 :
                 ((ver == VER_MPEG1) || (lay == LAYER_II)) ? K_LONG : K_SHORT;
  assign num   = NUM_W'(br) * NUM_W'(kcoef);

  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(br);

  always_comb begin
    stp_win    = win_r;
    stp_fill   = fill_r;
    stp_skip   = skip_r;
    stp_frames = frames_r;
    stp_sum    = sum_r;
    stp_prev   = prev_br_r;
    stp_rc     = rc_r;
    stp_first  = first_br_r;
    if (skip_r != '0) begin
      stp_skip = skip_r - 1'b1;
    end else if (fill_r != 2'd3) begin
      stp_win  = {win_r[15:0], in_byte};
      stp_fill = fill_r + 1'b1;
    end else if (hdr_ok) begin
      stp_win  = '0;
      stp_fill = '0;
      if (frames_r == '0) stp_first = br;
      if (frames_r != FC_MAX) stp_frames = frames_r + 1'b1;
      stp_sum  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      if ((prev_br_r != '0) && (br != prev_br_r)) stp_rc = 1'b1;
      stp_prev = br;
    end else begin
      stp_win = {win_r[15:0], in_byte};
    end
    // a miss and, at stream end, the bytes left in the window
    lost_wide = {2'b00, lost_r} + (LOST_W + 2)'(miss)
              + (LOST_W + 2)'(in_last ? stp_fill : 2'd0);
    stp_lost  = (lost_wide[LOST_W+1:LOST_W] != 2'b00) ? LOST_MAX : lost_wide[LOST_W-1:0];
  end

  // totals, with the leading tag frame taken out when configured
  always_comb begin
    t_fc  = stp_frames;
    t_sum = stp_sum;
    if (tag_r && (stp_frames != '0)) begin
      t_fc  = stp_frames - 1'b1;
      t_sum = (stp_sum >= SUM_W'(stp_first)) ? stp_sum - SUM_W'(stp_first) : '0;
    end
  end

  always_comb begin
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    skip_nxt     = skip_r;
    frames_nxt   = frames_r;
    sum_nxt      = sum_r;
    lost_nxt     = lost_r;
    prev_br_nxt  = prev_br_r;
    rc_nxt       = rc_r;
    first_br_nxt = first_br_r;
    if (cmd.accept) begin
      if (in_last) begin
        win_nxt      = '0;
        fill_nxt     = '0;
        skip_nxt     = '0;
        frames_nxt   = '0;
        sum_nxt      = '0;
        lost_nxt     = '0;
        prev_br_nxt  = '0;
        rc_nxt       = 1'b0;
        first_br_nxt = '0;
      end else begin
        win_nxt      = stp_win;
        fill_nxt     = stp_fill;
        skip_nxt     = stp_skip;
        frames_nxt   = stp_frames;
        sum_nxt      = stp_sum;
        lost_nxt     = stp_lost;
        prev_br_nxt  = stp_prev;
        rc_nxt       = stp_rc;
        first_br_nxt = stp_first;
      end
    end
    if (cmd.set_skip) skip_nxt = skip_val;
  end

  // restoring divide, quotient known to fit LEN_W bits
  assign trial    = {rem_r, quo_r[LEN_W-1]};
  assign trial_ge = (trial >= {1'b0, h_sr_r});

  // layer I counts 4-byte slots; length wraps at LEN_W bits
  assign len_pad  = quo_r + LEN_W'(h_pad_r);
  assign len      = (h_lay_r == LAYER_I) ? {len_pad[LEN_W-3:0], 2'b00} : len_pad;
  assign skip_val = (len > LEN_W'(4)) ? len - LEN_W'(4) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r      <= 1'b0;
      win_r      <= '0;
      fill_r     <= '0;
      skip_r     <= '0;
      frames_r   <= '0;
      sum_r      <= '0;
      lost_r     <= '0;
      prev_br_r  <= '0;
      rc_r       <= 1'b0;
      first_br_r <= '0;
    end else begin
      if (cfg_wr_en) tag_r <= cfg_wr_data;
      win_r      <= win_nxt;
      fill_r     <= fill_nxt;
      skip_r     <= skip_nxt;
      frames_r   <= frames_nxt;
      sum_r      <= sum_nxt;
      lost_r     <= lost_nxt;
      prev_br_r  <= prev_br_nxt;
      rc_r       <= rc_nxt;
      first_br_r <= first_br_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.hdr_found) begin
      h_ver_r  <= ver;
      h_lay_r  <= lay;
      h_br_r   <= br;
      h_sr_r   <= sr;
      h_pad_r  <= pad;
      h_cm_r   <= cm;
      h_fc_r   <= stp_frames;
      h_sum_r  <= stp_sum;
      h_lost_r <= stp_lost;
      h_rc_r   <= stp_rc;
      rem_r    <= SR_W'(num[NUM_W-1:LEN_W]);
      quo_r    <= num[LEN_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? SR_W'(trial - {1'b0, h_sr_r}) : trial[SR_W-1:0];
      quo_r <= {quo_r[LEN_W-2:0], trial_ge};
    end
    if (cmd.accept && in_last) begin
      t_fc_r   <= t_fc;
      t_sum_r  <= t_sum;
      t_lost_r <= stp_lost;
      t_rc_r   <= stp_rc;
    end
    if (cmd.load_hdr) begin
      out_kind_r <= KIND_FRAME;
      out_data_r <= {h_rc_r, h_lost_r, h_sum_r, FC_OUT_W'(h_fc_r), len,
                     h_cm_r, h_pad_r, h_sr_r, h_br_r, h_lay_r, h_ver_r};
    end else if (cmd.load_tot) begin
      out_kind_r <= KIND_TOTALS;
      out_data_r <= {t_rc_r, t_lost_r, t_sum_r, FC_OUT_W'(t_fc_r), {LEN_W{1'b0}},
                     2'b00, 1'b0, {SR_W{1'b0}}, {BR_W{1'b0}}, 2'b00, 2'b00};
    end
  end

  assign out_tdata = {{(TDATA_W - PAYLOAD_W){1'b0}}, out_data_r};
  assign out_tuser = out_kind_r;

endmodule

`default_nettype wire
